FILE: src/touch_swipe_detector_defines.svh
// Assertion macros shared by the swipe detector RTL.
`ifndef TOUCH_SWIPE_DETECTOR_DEFINES_SVH
`define TOUCH_SWIPE_DETECTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define TSD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while in reset.
`define TSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/tsd_pkg.sv
// Types and constants shared by the touch swipe detector modules.
package tsd_pkg;

	localparam int COORD_W = 12;
	localparam int STATUS_W = 8;
	localparam int SWIPE_W = 2;

	// Status byte layout.
	localparam int READY_BIT = 7;
	localparam logic [STATUS_W-1:0] COUNT_MASK = 8'h0F;

	// Edge zone is screen_width / 6, done as a multiply by a scaled reciprocal.
	localparam int EDGE_DIV = 6;
	localparam int EDGE_SHIFT = 14;
	localparam int EDGE_RECIP = (1 << EDGE_SHIFT) / EDGE_DIV + 1;
	localparam int PROD_W = COORD_W + EDGE_SHIFT;

	// Register indexes.
	localparam logic CFG_SWIPE_THRESHOLD = 1'b0;
	localparam logic CFG_SCREEN_WIDTH = 1'b1;

	localparam logic [COORD_W-1:0] THRESHOLD_RST = 12'd60;
	localparam logic [COORD_W-1:0] EDGE_RST = 12'd80;
	localparam logic [COORD_W-1:0] UPPER_RST = 12'd400;

	// Item kinds.
	localparam logic KIND_POLL = 1'b0;
	localparam logic KIND_SUPPRESS = 1'b1;

	// Swipe codes.
	localparam logic [SWIPE_W-1:0] SWIPE_NONE = 2'd0;
	localparam logic [SWIPE_W-1:0] SWIPE_NEXT = 2'd1;
	localparam logic [SWIPE_W-1:0] SWIPE_PREV = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0] threshold;
		logic [COORD_W-1:0] edge_zone;
		logic [COORD_W-1:0] upper;
	} cfg_t;

	typedef struct packed {
		logic kind;
		logic read_ok;
		logic [STATUS_W-1:0] status_byte;
		logic [COORD_W-1:0] touch_x;
		logic [COORD_W-1:0] touch_y;
	} item_t;

	typedef struct packed {
		logic pressed;
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic [SWIPE_W-1:0] swipe;
		logic show_arrows;
	} res_t;

endpackage

FILE: src/tsd_cfg.sv
// Configuration registers, with the edge zone bounds derived at write time.
module tsd_cfg import tsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wen,
	input  logic cfg_index,
	input  logic [COORD_W-1:0] cfg_data,
	output cfg_t cfg
);

	logic [COORD_W-1:0] threshold_q;
	logic [COORD_W-1:0] edge_q;
	logic [COORD_W-1:0] upper_q;
	logic [PROD_W-1:0] edge_prod;
	logic [COORD_W-1:0] edge_new;

	// The reciprocal error stays below one sixth over the 12-bit range,
	// so the truncated product equals the integer quotient.
	assign edge_prod = PROD_W'(cfg_data) * PROD_W'(EDGE_RECIP);
	assign edge_new = edge_prod[PROD_W-1:EDGE_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			edge_q <= EDGE_RST;
			upper_q <= UPPER_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_SWIPE_THRESHOLD: threshold_q <= cfg_data;
				CFG_SCREEN_WIDTH: begin
					edge_q <= edge_new;
					upper_q <= cfg_data - edge_new;
				end
				default: ;
			endcase
		end
	end

	assign cfg.threshold = threshold_q;
	assign cfg.edge_zone = edge_q;
	assign cfg.upper = upper_q;

endmodule

FILE: src/tsd_core.sv
// Gesture state and the per-sample press, release and swipe evaluation.
module tsd_core import tsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  item_t item,
	input  cfg_t cfg,
	output res_t res
);

	logic active_q;
	logic fired_q;
	logic suppressed_q;
	logic [COORD_W-1:0] start_x_q;
	logic [COORD_W-1:0] start_y_q;
	logic [COORD_W-1:0] last_x_q;
	logic [COORD_W-1:0] last_y_q;

	logic is_poll;
	logic pressed;
	logic [COORD_W-1:0] adx;
	logic [COORD_W-1:0] ady;
	logic in_zone;
	logic swipe_ok;

	assign is_poll = (item.kind == KIND_POLL);
	assign pressed = item.read_ok && item.status_byte[READY_BIT] &&
		((item.status_byte & COUNT_MASK) != '0);

	assign adx = (last_x_q >= start_x_q) ? (last_x_q - start_x_q) : (start_x_q - last_x_q);
	assign ady = (last_y_q >= start_y_q) ? (last_y_q - start_y_q) : (start_y_q - last_y_q);
	assign in_zone = (start_x_q > cfg.edge_zone) && (start_x_q < cfg.upper);

	// A release only judges a touch that is still open and has not fired yet.
	assign swipe_ok = !pressed && active_q && !fired_q && !suppressed_q && in_zone &&
		(adx >= cfg.threshold) && (adx > ady);

	always_comb begin
		res.pressed = pressed;
		res.point_x = pressed ? item.touch_x : last_x_q;
		res.point_y = pressed ? item.touch_y : last_y_q;
		res.show_arrows = pressed && !active_q;
		if (swipe_ok) begin
			res.swipe = (last_x_q < start_x_q) ? SWIPE_NEXT : SWIPE_PREV;
		end else begin
			res.swipe = SWIPE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			fired_q <= 1'b0;
			suppressed_q <= 1'b0;
			start_x_q <= '0;
			start_y_q <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (fire) begin
			if (!is_poll) begin
				suppressed_q <= 1'b1;
			end else if (pressed) begin
				last_x_q <= item.touch_x;
				last_y_q <= item.touch_y;
				if (!active_q) begin
					active_q <= 1'b1;
					fired_q <= 1'b0;
					suppressed_q <= 1'b0;
					start_x_q <= item.touch_x;
					start_y_q <= item.touch_y;
				end
			end else begin
				active_q <= 1'b0;
				if (swipe_ok) begin
					fired_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: src/touch_swipe_detector.sv
// Top level of the touch swipe detector: input register, core and result register.
//
// Input channel: in_valid/in_stall carry one item per transaction, either a
// touch poll sample or a request to suppress the current gesture.
// Output channel: out_valid/out_stall carry one result per poll sample;
// a suppress transaction updates the gesture state and yields no result.
// Path: the accepting edge loads the input register; the result register is loaded
// when that poll sample fires, which a stalled receiver can hold off.
// Throughput: one transaction per cycle while in_stall is low. The core reads the
// gesture state combinationally and updates it as each item fires.
// When the receiver stalls, the held result blocks the input register only
// if that register holds a poll sample; a further input is taken while a
// result waits, and suppress items pass regardless.
// Configuration: cfg_wen writes cfg_index 0 (swipe threshold) or 1 (screen width)
// on a rising edge; the user must write only while no transaction is in flight, and
// the block does not enforce this. Reset (arst_n low) empties both registers,
// clears the gesture state and loads threshold 60 and screen width 480.
`include "touch_swipe_detector_defines.svh"

module touch_swipe_detector import tsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wen,
	input  logic cfg_index,
	input  logic [COORD_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic kind,
	input  logic read_ok,
	input  logic [STATUS_W-1:0] status_byte,
	input  logic [COORD_W-1:0] touch_x,
	input  logic [COORD_W-1:0] touch_y,
	output logic out_valid,
	input  logic out_stall,
	output logic pressed,
	output logic [COORD_W-1:0] point_x,
	output logic [COORD_W-1:0] point_y,
	output logic [SWIPE_W-1:0] swipe,
	output logic show_arrows
);

	cfg_t cfg;
	logic valid_s1;
	item_t item_s1;
	logic valid_s2;
	res_t res_s2;
	res_t res;
	logic s2_free;
	logic fire;
	logic is_poll_s1;

	tsd_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	tsd_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.item(item_s1),
		.cfg(cfg),
		.res(res)
	);

	assign is_poll_s1 = (item_s1.kind == KIND_POLL);
	assign s2_free = !valid_s2 || !out_stall;
	assign fire = valid_s1 && (!is_poll_s1 || s2_free);
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.kind <= kind;
			item_s1.read_ok <= read_ok;
			item_s1.status_byte <= status_byte;
			item_s1.touch_x <= touch_x;
			item_s1.touch_y <= touch_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire && is_poll_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_poll_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign pressed = res_s2.pressed;
	assign point_x = res_s2.point_x;
	assign point_y = res_s2.point_y;
	assign swipe = res_s2.swipe;
	assign show_arrows = res_s2.show_arrows;

	`TSD_ASSERT_NOW(a_stall_needs_item, in_stall, valid_s1 && is_poll_s1, "stall without a blocked poll sample")
	`TSD_ASSERT_NOW(a_swipe_on_release, valid_s2 && (res_s2.swipe != SWIPE_NONE), !res_s2.pressed, "swipe reported on a press")
	`TSD_ASSERT_NOW(a_arrows_on_press, valid_s2 && res_s2.show_arrows, res_s2.pressed && (res_s2.swipe == SWIPE_NONE), "arrows without a press")
	`TSD_ASSERT_NEXT(a_result_loaded, fire && is_poll_s1, valid_s2, "poll sample produced no result")

endmodule

FILE: tb/sv/touch_swipe_detector_test.sv
// Self-checking testbench for the touch swipe detector: directed script, then random gestures.
module touch_swipe_detector_test;
	import tsd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STUCK_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 200;
	localparam logic [COORD_W-1:0] MAX_COORD = '1;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic cfg_index = CFG_SWIPE_THRESHOLD;
	logic [COORD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = KIND_POLL;
	logic read_ok = 1'b0;
	logic [STATUS_W-1:0] status_byte = '0;
	logic [COORD_W-1:0] touch_x = '0;
	logic [COORD_W-1:0] touch_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic pressed;
	logic [COORD_W-1:0] point_x;
	logic [COORD_W-1:0] point_y;
	logic [SWIPE_W-1:0] swipe;
	logic show_arrows;

	touch_swipe_detector dut (.*);

	typedef struct {
		item_t stim;
		bit typed;
		res_t want;
	} script_row_t;

	// Gesture tracker state and register copies.
	logic [COORD_W-1:0] thr_cfg = THRESHOLD_RST;
	logic [COORD_W-1:0] width_cfg = 12'd480;
	bit tracking, fired, muted;
	logic [COORD_W-1:0] start_px, start_py, last_px, last_py;

	res_t pending_results[$];
	bit calm;
	int failures, n_items, n_results, n_next, n_prev, n_settings, stuck;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Advances the tracker state; for a poll, also works out its result and returns 1.
	function automatic bit track_gesture(input item_t it, output res_t r);
		logic [COORD_W-1:0] adx, ady, zone;
		bit down, inner;
		r = '0;
		if (it.kind == KIND_SUPPRESS) begin
			muted = 1'b1;
			return 1'b0;
		end
		down = it.read_ok && it.status_byte[READY_BIT] &&
			((it.status_byte & COUNT_MASK) != '0);
		r.swipe = SWIPE_NONE;
		if (down) begin
			last_px = it.touch_x;
			last_py = it.touch_y;
			if (!tracking) begin
				tracking = 1'b1;
				fired = 1'b0;
				muted = 1'b0;
				start_px = it.touch_x;
				start_py = it.touch_y;
				r.show_arrows = 1'b1;
			end
		end else begin
			if (tracking && !fired) begin
				adx = (last_px >= start_px) ? last_px - start_px : start_px - last_px;
				ady = (last_py >= start_py) ? last_py - start_py : start_py - last_py;
				zone = width_cfg / EDGE_DIV;
				inner = (start_px > zone) && (start_px < width_cfg - zone);
				if (adx >= thr_cfg && adx > ady && inner && !muted) begin
					fired = 1'b1;
					r.swipe = (last_px < start_px) ? SWIPE_NEXT : SWIPE_PREV;
				end
			end
			tracking = 1'b0;
		end
		r.pressed = down;
		r.point_x = last_px;
		r.point_y = last_py;
		return 1'b1;
	endfunction

	function automatic logic [COORD_W-1:0] clamp12(input int v);
		if (v < 0)
			return '0;
		if (v > int'(MAX_COORD))
			return MAX_COORD;
		return v[COORD_W-1:0];
	endfunction

	function automatic int jitter(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic item_t poll(input logic rd, input logic [STATUS_W-1:0] st,
		input int x, input int y);
		item_t it;
		it.kind = KIND_POLL;
		it.read_ok = rd;
		it.status_byte = st;
		it.touch_x = clamp12(x);
		it.touch_y = clamp12(y);
		return it;
	endfunction

	function automatic item_t suppress_req();
		item_t it;
		it = item_t'({$urandom, $urandom});
		it.kind = KIND_SUPPRESS;
		return it;
	endfunction

	function automatic item_t touch_down(input int x, input int y);
		return poll(1'b1, {1'b1, 3'($urandom), 4'($urandom_range(1, 15))}, x, y);
	endfunction

	// A release comes from a failed read, a controller that is not ready, or zero touches.
	function automatic item_t touch_up();
		int x, y;
		x = $urandom_range(0, 4095);
		y = $urandom_range(0, 4095);
		case ($urandom_range(0, 2))
			0: return poll(1'b0, 8'($urandom), x, y);
			1: return poll(1'b1, {1'b0, 7'($urandom)}, x, y);
			default: return poll(1'b1, {1'b1, 3'($urandom), 4'h0}, x, y);
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send(input item_t it, input bit typed = 1'b0, input res_t want = '0);
		res_t predicted;
		int gap;
		in_valid <= 1'b1;
		kind <= it.kind;
		read_ok <= it.read_ok;
		status_byte <= it.status_byte;
		touch_x <= it.touch_x;
		touch_y <= it.touch_y;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_items++;
		if (track_gesture(it, predicted))
			pending_results.push_back(typed ? want : predicted);
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		while (pending_results.size() != 0)
			@(posedge clk);
		// A suppress transaction may still sit in the pipeline.
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input int thr, input int wid);
		drain();
		cfg_wen <= 1'b1;
		cfg_index <= CFG_SWIPE_THRESHOLD;
		cfg_data <= 12'(thr);
		@(posedge clk);
		cfg_index <= CFG_SCREEN_WIDTH;
		cfg_data <= 12'(wid);
		@(posedge clk);
		cfg_wen <= 1'b0;
		thr_cfg = 12'(thr);
		width_cfg = 12'(wid);
		n_settings++;
	endtask

	// One touch: start near the edge-zone limits or anywhere, travel close to the
	// threshold or anywhere, with suppress requests mixed in now and then.
	task automatic run_gesture();
		int zone, hi, sx, sy, ex, ey, mag, dir, steps;
		zone = int'(width_cfg) / EDGE_DIV;
		hi = int'(width_cfg) - zone;
		if ($urandom_range(0, 9) == 0)
			send(suppress_req());
		case ($urandom_range(0, 4))
			0: sx = zone + jitter(1);
			1: sx = hi + jitter(1);
			2: sx = $urandom_range(0, 4095);
			default: sx = $urandom_range(0, int'(width_cfg));
		endcase
		sy = $urandom_range(0, 4095);
		if ($urandom_range(0, 3) == 0)
			mag = $urandom_range(0, 4095);
		else
			mag = int'(thr_cfg) + jitter(3);
		if (mag < 0)
			mag = 0;
		dir = $urandom_range(0, 1) ? 1 : -1;
		ex = sx + dir * mag;
		if ($urandom_range(0, 2) != 0)
			ey = sy + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, mag));
		else
			ey = sy + ($urandom_range(0, 1) ? 1 : -1) * (mag + jitter(2));
		steps = $urandom_range(0, 4);
		send(touch_down(sx, sy));
		for (int k = 1; k <= steps; k++) begin
			send(touch_down(sx + (ex - sx) * k / (steps + 1) + jitter(2), sy + jitter(2)));
			if ($urandom_range(0, 14) == 0)
				send(suppress_req());
		end
		send(touch_down(ex, ey));
		if ($urandom_range(0, 9) == 0)
			send(suppress_req());
		send(touch_up());
		if ($urandom_range(0, 7) == 0)
			send(touch_up());
	endtask

	// Receiver stalls: runs of random length, mostly short.
	always @(posedge clk) begin : stall_gen
		int left;
		if (calm) begin
			out_stall <= 1'b0;
			left = 0;
		end else if (left > 0) begin
			left--;
		end else if ($urandom_range(0, 99) < 35) begin
			out_stall <= 1'b1;
			left = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
			left = $urandom_range(0, 5);
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no poll sample waiting for it");
				failures++;
			end else begin
				want = pending_results.pop_front();
				n_results++;
				if (want.swipe == SWIPE_NEXT)
					n_next++;
				if (want.swipe == SWIPE_PREV)
					n_prev++;
				check_field("pressed", want.pressed, pressed);
				check_field("point_x", want.point_x, point_x);
				check_field("point_y", want.point_y, point_y);
				check_field("swipe", want.swipe, swipe);
				check_field("show_arrows", want.show_arrows, show_arrows);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck <= 0;
			else
				stuck <= stuck + 1;
			if (stuck == STUCK_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		script_row_t script[$];
		int thr_set[PHASES], wid_set[PHASES];

		tracking = 1'b0;
		fired = 1'b0;
		muted = 1'b0;
		start_px = '0;
		start_py = '0;
		last_px = '0;
		last_py = '0;

		// Default registers: threshold 60, edge zone 80, starts allowed in 81..399.
		script.push_back('{poll(1'b0, 8'h00, 0, 0), 1'b1,
			res_t'{1'b0, 12'd0, 12'd0, SWIPE_NONE, 1'b0}});
		script.push_back('{poll(1'b1, 8'h81, 240, 100), 1'b1,
			res_t'{1'b1, 12'd240, 12'd100, SWIPE_NONE, 1'b1}});
		script.push_back('{poll(1'b1, 8'hFF, 100, 100), 1'b0, '0});
		script.push_back('{poll(1'b1, 8'h80, 0, 0), 1'b1,
			res_t'{1'b0, 12'd100, 12'd100, SWIPE_NEXT, 1'b0}});
		script.push_back('{poll(1'b1, 8'h81, 81, 4095), 1'b0, '0});
		script.push_back('{poll(1'b1, 8'h8F, 4095, 4095), 1'b0, '0});
		script.push_back('{poll(1'b1, 8'h0F, 4095, 4095), 1'b1,
			res_t'{1'b0, 12'd4095, 12'd4095, SWIPE_PREV, 1'b0}});
		// A start right on the edge-zone boundary never swipes.
		script.push_back('{poll(1'b1, 8'h81, 80, 0), 1'b0, '0});
		script.push_back('{poll(1'b1, 8'hF1, 0, 0), 1'b0, '0});
		script.push_back('{poll(1'b0, 8'hFF, 4095, 4095), 1'b1,
			res_t'{1'b0, 12'd0, 12'd0, SWIPE_NONE, 1'b0}});
		script.push_back('{poll(1'b1, 8'h81, 399, 200), 1'b0, '0});
		script.push_back('{poll(1'b1, 8'h81, 300, 200), 1'b0, '0});
		script.push_back('{suppress_req(), 1'b0, '0});
		script.push_back('{poll(1'b1, 8'h00, 0, 0), 1'b1,
			res_t'{1'b0, 12'd300, 12'd200, SWIPE_NONE, 1'b0}});
		// Horizontal travel equal to the vertical travel does not count.
		script.push_back('{poll(1'b1, 8'h81, 200, 200), 1'b0, '0});
		script.push_back('{poll(1'b1, 8'h81, 140, 260), 1'b0, '0});
		script.push_back('{poll(1'b1, 8'h70, 0, 0), 1'b0, '0});
		script.push_back('{poll(1'b1, 8'h81, 200, 200), 1'b0, '0});
		script.push_back('{poll(1'b1, 8'h81, 140, 259), 1'b0, '0});
		script.push_back('{poll(1'b1, 8'h8F & 8'hF0, 0, 0), 1'b1,
			res_t'{1'b0, 12'd140, 12'd259, SWIPE_NEXT, 1'b0}});
		// Release with no touch in progress holds the last point.
		script.push_back('{poll(1'b0, 8'h81, 7, 7), 1'b1,
			res_t'{1'b0, 12'd140, 12'd259, SWIPE_NONE, 1'b0}});
		script.push_back('{suppress_req(), 1'b0, '0});
		script.push_back('{poll(1'b1, 8'h81, 400, 0), 1'b0, '0});
		script.push_back('{poll(1'b1, 8'h81, 0, 0), 1'b0, '0});
		script.push_back('{poll(1'b0, 8'h00, 0, 0), 1'b0, '0});

		thr_set = '{0, 4095, 1, 0, 0, 0, 60, 0};
		wid_set = '{6, 4095, 4095, 0, 0, 0, 480, 0};
		for (int p = 3; p < PHASES; p++) begin
			if (p != 6) begin
				thr_set[p] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
					: $urandom_range(0, 300);
				wid_set[p] = $urandom_range(6, 4095);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send(script[i].stim, script[i].typed, script[i].want);
		in_valid <= 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			configure(thr_set[p], wid_set[p]);
			calm = (p == 4);
			while (n_items < script.size() + (p + 1) * ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 6) == 0)
					send(item_t'({$urandom, $urandom}));
				else
					run_gesture();
			end
			in_valid <= 1'b0;
		end
		calm = 1'b0;

		drain();
		foreach (pending_results[i]) begin
			$error("poll sample left without a result");
			failures++;
		end

		$display("Run covered %0d input transactions under %0d register settings after reset,",
			n_items, n_settings);
		$display("with %0d results checked: %0d next swipes and %0d previous swipes.",
			n_results, n_next, n_prev);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
